// ===== rtl/core/best_fit_segment_allocator_core_macros.svh =====
// Assertion macros for the segment allocator.
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_CORE_MACROS_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/bfsa_pkg.sv =====
package bfsa_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF = 24;
  localparam int unsigned STAMP_W = 32;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_FIT = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_BAD_FREE = 3'd3;
  localparam logic [2:0] ST_ZERO = 3'd4;

  typedef struct packed {
    logic clear;
    logic start_scan;
    logic scan_step;
    logic prime_step;
    logic alloc_commit;
    logic free_commit;
    logic merge_step;
    logic stamp_commit;
  } bfsa_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic clear_last;
    logic found;
    logic exact;
    logic has_spare;
  } bfsa_sts_t;

endpackage

// ===== rtl/core/bfsa_datapath.sv =====
`include "best_fit_segment_allocator_core_macros.svh"
module bfsa_datapath #(
  parameter int unsigned MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned ADDR_BITS = bfsa_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfsa_pkg::bfsa_cmd_t  cmd,
  output bfsa_pkg::bfsa_sts_t  sts,
  input  logic                 op_free,
  input  logic [ADDR_BITS:0]   req_size,
  input  logic [ADDR_BITS-1:0] free_start,
  input  logic [ADDR_BITS:0]   pool_size,
  output logic [ADDR_BITS-1:0] res_start,
  output logic [ADDR_BITS:0]   res_size,
  output logic [ADDR_BITS:0]   free_bytes
);
  import bfsa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);

  logic [MAX_SEGMENTS-1:0] vld_r;
  logic [MAX_SEGMENTS-1:0] busy_r;
  logic [ADDR_BITS-1:0]    base_mem [MAX_SEGMENTS];
  logic [ADDR_BITS:0]      len_mem [MAX_SEGMENTS];
  logic [STAMP_W-1:0]      stamp_mem [MAX_SEGMENTS];

  logic [IW-1:0]        idx_r;
  logic [ADDR_BITS-1:0] rd_base_r;
  logic [ADDR_BITS:0]   rd_len_r;
  logic [STAMP_W-1:0]   rd_stamp_r;
  logic [IW-1:0]        rd_idx_r;
  logic                 rd_vld_r;
  logic                 rd_busy_r;

  logic                 found_r;
  logic [IW-1:0]        best_r;
  logic [ADDR_BITS-1:0] best_base_r;
  logic [ADDR_BITS:0]   best_len_r;
  logic [STAMP_W-1:0]   best_stamp_r;
  logic                 spare_ok_r;
  logic [IW-1:0]        spare_r;
  logic [STAMP_W-1:0]   stamp_cnt_r;
  logic [ADDR_BITS:0]   free_bytes_r;
  logic [ADDR_BITS-1:0] res_start_r;
  logic [ADDR_BITS:0]   res_size_r;
  logic [ADDR_BITS-1:0] mbase_r;
  logic [ADDR_BITS:0]   mlen_r;

  logic [ADDR_BITS:0]   end_a;
  logic [ADDR_BITS:0]   rd_end;
  logic                 cand;
  logic                 better;

  assign end_a = {1'b0, best_base_r} + best_len_r;
  assign rd_end = {1'b0, rd_base_r} + rd_len_r;
  assign cand = rd_vld_r && !rd_busy_r && (rd_len_r >= req_size);
  assign better = !found_r || (rd_len_r < best_len_r) ||
                  ((rd_len_r == best_len_r) && (rd_stamp_r > best_stamp_r));

  assign sts = '{scan_last: (idx_r == IW'(MAX_SEGMENTS - 1)),
                 clear_last: (idx_r == IW'(MAX_SEGMENTS - 1)),
                 found: found_r,
                 exact: (best_len_r == req_size),
                 has_spare: spare_ok_r};
  assign res_start = res_start_r;
  assign res_size = res_size_r;
  assign free_bytes = free_bytes_r;

  always_ff @(posedge clk) begin
    rd_base_r <= base_mem[idx_r];
    rd_len_r <= len_mem[idx_r];
    rd_stamp_r <= stamp_mem[idx_r];
    rd_idx_r <= idx_r;
    if (!rst_n || cmd.clear) begin
      if (cmd.clear) begin
        base_mem[idx_r] <= '0;
        len_mem[idx_r] <= (idx_r == '0) ? pool_size : '0;
        stamp_mem[idx_r] <= '0;
      end
    end else if (cmd.alloc_commit) begin
      if (sts.exact) begin
        stamp_mem[best_r] <= best_stamp_r;
      end else begin
        base_mem[spare_r] <= best_base_r;
        len_mem[spare_r] <= req_size;
        stamp_mem[spare_r] <= '0;
        base_mem[best_r] <= ADDR_BITS'({1'b0, best_base_r} + req_size);
        len_mem[best_r] <= best_len_r - req_size;
        stamp_mem[best_r] <= stamp_cnt_r;
      end
    end else if (cmd.stamp_commit) begin
      base_mem[best_r] <= mbase_r;
      len_mem[best_r] <= mlen_r;
      stamp_mem[best_r] <= stamp_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= '0;
      busy_r <= '0;
      rd_vld_r <= 1'b0;
      rd_busy_r <= 1'b0;
      found_r <= 1'b0;
      spare_ok_r <= 1'b0;
      stamp_cnt_r <= '0;
      free_bytes_r <= '0;
    end else begin
      rd_vld_r <= vld_r[idx_r];
      rd_busy_r <= busy_r[idx_r];
      if (cmd.clear) begin
        vld_r <= MAX_SEGMENTS'(1);
        busy_r <= '0;
        stamp_cnt_r <= STAMP_W'(1);
        free_bytes_r <= pool_size;
        idx_r <= sts.clear_last ? '0 : idx_r + 1'b1;
      end else if (cmd.start_scan) begin
        idx_r <= '0;
        found_r <= 1'b0;
        spare_ok_r <= 1'b0;
        res_start_r <= '0;
        res_size_r <= '0;
      end else if (cmd.scan_step || cmd.prime_step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.scan_step && !op_free) begin
        if (!rd_vld_r && !spare_ok_r) begin
          spare_ok_r <= 1'b1;
          spare_r <= rd_idx_r;
        end
        if (cand && better) begin
          found_r <= 1'b1;
          best_r <= rd_idx_r;
          best_base_r <= rd_base_r;
          best_len_r <= rd_len_r;
          best_stamp_r <= rd_stamp_r;
        end
      end
      if (cmd.scan_step && op_free && !found_r && rd_vld_r && rd_busy_r &&
          rd_base_r == free_start) begin
        found_r <= 1'b1;
        best_r <= rd_idx_r;
        mbase_r <= rd_base_r;
        mlen_r <= rd_len_r;
        best_base_r <= rd_base_r;
        best_len_r <= rd_len_r;
      end
      if (cmd.merge_step && rd_vld_r && !rd_busy_r && rd_idx_r != best_r) begin
        if (rd_end == {1'b0, best_base_r}) begin
          mbase_r <= rd_base_r;
          mlen_r <= mlen_r + rd_len_r;
          vld_r[rd_idx_r] <= 1'b0;
        end else if ({1'b0, rd_base_r} == end_a) begin
          mlen_r <= mlen_r + rd_len_r;
          vld_r[rd_idx_r] <= 1'b0;
        end
      end
      if (cmd.merge_step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.free_commit) begin
        busy_r[best_r] <= 1'b0;
        free_bytes_r <= free_bytes_r + best_len_r;
        res_start_r <= best_base_r;
        res_size_r <= best_len_r;
        idx_r <= '0;
      end
      if (cmd.stamp_commit) begin
        stamp_cnt_r <= stamp_cnt_r + 1'b1;
      end
      if (cmd.alloc_commit) begin
        free_bytes_r <= free_bytes_r - req_size;
        res_start_r <= best_base_r;
        res_size_r <= req_size;
        if (sts.exact) begin
          busy_r[best_r] <= 1'b1;
        end else begin
          vld_r[spare_r] <= 1'b1;
          busy_r[spare_r] <= 1'b1;
          stamp_cnt_r <= stamp_cnt_r + 1'b1;
        end
      end
    end
  end

  `BFSA_ASSERT_NEXT(a_clear_entry0, clk, rst_n, cmd.clear, vld_r[0])
  `BFSA_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1,
                    $onehot0({cmd.clear, cmd.alloc_commit, cmd.free_commit, cmd.stamp_commit}))
  `BFSA_ASSERT_IMPL(a_free_hit, clk, rst_n, cmd.free_commit, found_r)
endmodule

// ===== rtl/core/bfsa_ctrl.sv =====
`include "best_fit_segment_allocator_core_macros.svh"
module bfsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                start,
  input  logic                op_free,
  input  logic                size_zero,
  input  bfsa_pkg::bfsa_sts_t sts,
  output bfsa_pkg::bfsa_cmd_t cmd,
  output logic                idle,
  output logic                done,
  output logic [2:0]          status
);
  import bfsa_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_PRIME  = 8'b00000100,
    S_SCAN   = 8'b00001000,
    S_DECIDE = 8'b00010000,
    S_PRIME2 = 8'b00100000,
    S_MERGE  = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] status_r, status_nxt;
  logic last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    status_nxt = status_r;
    last_nxt = 1'b0;
    cmd = '0;
    done = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.start_scan = 1'b1;
          status_nxt = ST_OK;
          if (!op_free && size_zero) begin
            status_nxt = ST_ZERO;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PRIME;
          end
        end
      end
      S_PRIME: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        last_nxt = sts.scan_last;
        if (last_r) begin
          cmd.scan_step = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.found) begin
          status_nxt = op_free ? ST_BAD_FREE : ST_NO_FIT;
          state_nxt = S_DONE;
        end else if (op_free) begin
          cmd.free_commit = 1'b1;
          state_nxt = S_PRIME2;
        end else if (!sts.exact && !sts.has_spare) begin
          status_nxt = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd.alloc_commit = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_PRIME2: begin
        cmd.prime_step = 1'b1;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge_step = 1'b1;
        last_nxt = sts.scan_last;
        if (last_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        done = 1'b1;
        cmd.stamp_commit = op_free && (status_r == ST_OK);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    if (cfg_we) begin
      state_nxt = S_CLEAR;
      cmd = '0;
      cmd.start_scan = 1'b1;
    end
  end

  assign idle = (state_r == S_IDLE) && !cfg_we;
  assign status = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      status_r <= ST_OK;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      status_r <= status_nxt;
      last_r <= last_nxt;
    end
  end

  `BFSA_ASSERT_NEXT(a_done_idle, clk, rst_n, done && !cfg_we, state_r == S_IDLE)
  `BFSA_ASSERT_IMPL(a_no_start_busy, clk, rst_n, state_r != S_IDLE, !idle)
  `BFSA_ASSERT_NEXT(a_cfg_clear, clk, rst_n, cfg_we, state_r == S_CLEAR)
endmodule

// ===== rtl/core/best_fit_segment_allocator_core.sv =====
// Best-fit segment allocator core.
// Input words arrive on in_tvalid/in_tready/in_tdata: operation selects allocate (0) or
// free (1), req_size is the allocation length and free_start the base to release.
// Each input word yields one result word on out_tvalid/out_tready/out_tdata carrying a
// status code, the granted or freed segment, and the free byte count afterward.
// Each request scans the segment table once through a registered read port, one entry
// per cycle, and a free scans the table a second time to merge neighbors; a zero-size
// allocate skips the scan. One word is in work at a time, so a new word is accepted
// only after the last one's result has been produced and has left the output register.
// After reset, and after every cfg_we write of the pool size, a clearing pass over every
// table entry rebuilds the table as one free segment; no input is taken then.
// The result sits in an output register; while the receiver stalls, the result waits
// there and no new input word is accepted until the register drains.
// The user must write the pool size only while idle; the block does not enforce it.
`include "best_fit_segment_allocator_core_macros.svh"
module best_fit_segment_allocator_core #(
  parameter int unsigned MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [24:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[0], req_size[25:1], free_start[49:26], zero fill
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], seg_start[26:3], seg_size[51:27], available[76:52], zero fill
  output logic [79:0] out_tdata
);
  import bfsa_pkg::*;

  localparam int unsigned ADDR_BITS = ADDR_BITS_DEF;

  bfsa_cmd_t cmd;
  bfsa_sts_t sts;
  logic idle, done;
  logic [2:0] status;
  logic [ADDR_BITS:0] pool_r;
  logic [ADDR_BITS:0] pool_nxt;
  logic op_r;
  logic [ADDR_BITS:0] req_r;
  logic [ADDR_BITS-1:0] fstart_r;
  logic [ADDR_BITS-1:0] res_start;
  logic [ADDR_BITS:0] res_size;
  logic [ADDR_BITS:0] free_bytes;
  logic accept;
  logic ovalid_r;
  logic [79:0] odata_r;
  logic [24:0] avail_w;

  assign in_tready = idle && !ovalid_r;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    pool_nxt = (ADDR_BITS + 1)'(cfg_wdata);
    if (cfg_wdata == '0) begin
      pool_nxt = (ADDR_BITS + 1)'(1);
    end else if ({7'd0, cfg_wdata} > (32'd1 << ADDR_BITS)) begin
      pool_nxt = (ADDR_BITS + 1)'(1) << ADDR_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= (ADDR_BITS + 1)'(1) << ADDR_BITS;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_r <= pool_nxt;
      end
      if (done) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_tdata[0];
      req_r <= in_tdata[ADDR_BITS+1:1];
      fstart_r <= in_tdata[2*ADDR_BITS+1:ADDR_BITS+2];
    end
    if (done) begin
      odata_r <= {3'd0, avail_w, 25'(res_size), 24'(res_start), status};
    end
  end

  assign avail_w = 25'(free_bytes);
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

  bfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .start     (accept),
    .op_free   (accept ? in_tdata[0] : op_r),
    .size_zero (in_tdata[ADDR_BITS+1:1] == '0),
    .sts       (sts),
    .cmd       (cmd),
    .idle      (idle),
    .done      (done),
    .status    (status)
  );

  bfsa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .op_free    (op_r),
    .req_size   (req_r),
    .free_start (fstart_r),
    .pool_size  (pool_r),
    .res_start  (res_start),
    .res_size   (res_size),
    .free_bytes (free_bytes)
  );

  `BFSA_ASSERT_IMPL(a_no_overwrite, clk, rst_n, done, !ovalid_r || out_tready)
  `BFSA_ASSERT_NEXT(a_cfg_blocks, clk, rst_n, cfg_we, !in_tready)
  `BFSA_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_tready, !out_tvalid)
endmodule
